@@ rtl/core/pfla_pkg.sv @@
package pfla_pkg;

	localparam int NUM_PAGES_DEF = 1024;
	localparam int MAX_BATCH_DEF = 16;

	localparam int TOTAL_W   = 11;
	localparam int USED_W    = 11;
	localparam int OP_W      = 2;
	localparam int COUNT_W   = 5;
	localparam int PAGE_IN_W = 10;
	localparam int PAGE_OUT_W = 11;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_FORMAT = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_IS_PRIMARY = 2'd1;

	localparam logic [TOTAL_W-1:0] TOTAL_PAGES_RST = 11'd1024;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [COUNT_W-1:0]   count;
		logic [PAGE_IN_W-1:0] page_in;
	} req_t;

	typedef struct packed {
		logic [PAGE_OUT_W-1:0] page_out;
		logic [STATUS_W-1:0]   status;
		logic                  last;
	} rsp_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_pages;
		logic               volume_is_primary;
	} cfg_t;

endpackage

@@ rtl/core/page_free_list_allocator_top.sv @@
// Page allocator over a singly linked free list kept in a one-port-read link memory. One
// request is taken at a time and req_stall stays high until its last response has entered
// the output register. Format writes one link per cycle and then gives one response.
// Allocate walks the list one page per cycle through the link memory's registered read
// port and checks the whole batch before it commits. The commit has a state of its own,
// and then one response is sent per page. Free, and a request rejected as soon as it
// arrives, go straight to a single response. A batch that runs off the end of the
// list is rejected only after the walk reaches that end. No clearing pass runs after
// reset; the link memory is meaningful once a format has run.
module page_free_list_allocator_top #(
	parameter int NUM_PAGES = pfla_pkg::NUM_PAGES_DEF,
	parameter int MAX_BATCH = pfla_pkg::MAX_BATCH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfla_pkg::TOTAL_W-1:0]    cfg_data,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  pfla_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output pfla_pkg::rsp_t                  rsp
);

	pfla_pkg::cfg_t cfg;
	logic           res_valid;
	logic           res_ready;
	pfla_pkg::rsp_t res;

	pfla_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pfla_core #(
		.NUM_PAGES (NUM_PAGES),
		.MAX_BATCH (MAX_BATCH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	pfla_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld_valid  (res_valid),
		.ld_ready  (res_ready),
		.ld        (res),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ rtl/core/pfla_cfg.sv @@
module pfla_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfla_pkg::TOTAL_W-1:0]    cfg_data,
	output pfla_pkg::cfg_t                  cfg
);

	pfla_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_pages <= pfla_pkg::TOTAL_PAGES_RST;
			cfg_q.volume_is_primary <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pfla_pkg::CFG_TOTAL_PAGES: cfg_q.total_pages <= cfg_data;
				pfla_pkg::CFG_VOLUME_IS_PRIMARY: cfg_q.volume_is_primary <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/pfla_out.sv @@
module pfla_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ld_valid,
	output logic           ld_ready,
	input  pfla_pkg::rsp_t ld,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pfla_pkg::rsp_t rsp
);

	logic           valid_q;
	pfla_pkg::rsp_t data_q;

	// The register takes a new result when it is empty or its current one leaves now.
	assign ld_ready = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld_ready) begin
			valid_q <= ld_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_ready && ld_valid) begin
			data_q <= ld;
		end
	end

endmodule

@@ rtl/core/pfla_core.sv @@
module pfla_core #(
	parameter int NUM_PAGES = pfla_pkg::NUM_PAGES_DEF,
	parameter int MAX_BATCH = pfla_pkg::MAX_BATCH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pfla_pkg::cfg_t cfg,
	input  logic           req_valid,
	output logic           req_stall,
	input  pfla_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_ready,
	output pfla_pkg::rsp_t res
);

	localparam int PW = $clog2(NUM_PAGES + 1);
	localparam int AW = $clog2(NUM_PAGES);
	localparam int CW = (PW > 12) ? PW : 12;
	localparam int NW = $clog2(MAX_BATCH + 1);
	localparam int BW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
	localparam int KW = (NW > pfla_pkg::COUNT_W) ? NW : pfla_pkg::COUNT_W;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_FORMAT    = 3'd1;
	localparam logic [2:0] ST_ALLOC     = 3'd2;
	localparam logic [2:0] ST_ALLOC_FIN = 3'd3;
	localparam logic [2:0] ST_EMIT      = 3'd4;
	localparam logic [2:0] ST_RESP      = 3'd5;

	logic [2:0]    state_q;
	logic [PW-1:0] head_q;
	logic [pfla_pkg::USED_W-1:0] used_q;
	logic          first_q;
	logic [NW-1:0] n_q;
	logic [PW-1:0] idx_q;

	logic [pfla_pkg::COUNT_W-1:0]  count_q;
	logic [pfla_pkg::STATUS_W-1:0] resp_status_q;
	logic [PW-1:0] batch_q [MAX_BATCH];
	logic [PW-1:0] rd_q;
	logic [PW-1:0] link_mem [NUM_PAGES];

	logic [CW-1:0] tp_raw;
	logic [CW-1:0] tp_w;
	logic [PW-1:0] null_w;
	logic [CW-1:0] null_ext;
	logic [PW-1:0] cur_w;
	logic          cur_null;
	logic [CW-1:0] idx_nxt;
	logic          fmt_last;
	logic [CW-1:0] page_ext;
	logic          free_bad;
	logic [CW-1:0] used_sum;
	logic          alloc_zero;
	logic          alloc_over;
	logic [KW-1:0] n_nxt;
	logic          batch_last;
	logic [pfla_pkg::STATUS_W-1:0] idle_status;
	logic [PW-1:0] reserved;
	logic [CW-1:0] emit_ext;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [PW-1:0] mem_wdata;
	logic          mem_re;

	assign tp_raw = CW'(cfg.total_pages);
	assign null_w = PW'(NUM_PAGES);
	assign null_ext = CW'(NUM_PAGES);

	always_comb begin
		if (tp_raw < CW'(2)) begin
			tp_w = CW'(2);
		end else if (tp_raw > CW'(NUM_PAGES)) begin
			tp_w = CW'(NUM_PAGES);
		end else begin
			tp_w = tp_raw;
		end
	end

	assign reserved = cfg.volume_is_primary ? PW'(2) : PW'(1);

	// The first hop of a walk starts at the head; later hops follow the link just read.
	assign cur_w = first_q ? head_q : rd_q;
	assign cur_null = cur_w >= null_w;

	assign idx_nxt = CW'(idx_q) + CW'(1);
	assign fmt_last = idx_nxt == tp_w;

	assign page_ext = CW'(req.page_in);
	assign free_bad = page_ext >= tp_w;
	assign used_sum = CW'(used_q) + CW'(req.count);
	assign alloc_zero = req.count == '0;
	assign alloc_over = (KW'(req.count) > KW'(MAX_BATCH)) || (used_sum > tp_w);

	assign n_nxt = KW'(n_q) + KW'(1);
	assign batch_last = n_nxt == KW'(count_q);
	assign emit_ext = CW'(batch_q[n_q[BW-1:0]]);

	always_comb begin
		case (req.op)
			pfla_pkg::OP_ALLOC: begin
				idle_status = (!alloc_zero && alloc_over) ? pfla_pkg::STATUS_SHORT
				                                         : pfla_pkg::STATUS_OK;
			end
			pfla_pkg::OP_FREE: begin
				idle_status = free_bad ? pfla_pkg::STATUS_BAD : pfla_pkg::STATUS_OK;
			end
			default: idle_status = pfla_pkg::STATUS_OK;
		endcase
	end

	assign req_stall = state_q != ST_IDLE;

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = fmt_last ? null_w : idx_nxt[PW-1:0];
		if (state_q == ST_FORMAT) begin
			mem_we = 1'b1;
		end else if (state_q == ST_IDLE && req_valid && req.op == pfla_pkg::OP_FREE
		             && !free_bad) begin
			mem_we = 1'b1;
			mem_waddr = page_ext[AW-1:0];
			mem_wdata = head_q;
		end
	end

	assign mem_re = (state_q == ST_ALLOC) && !cur_null;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= link_mem[cur_w[AW-1:0]];
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res.page_out = null_ext[pfla_pkg::PAGE_OUT_W-1:0];
		res.status = resp_status_q;
		res.last = 1'b1;
		if (state_q == ST_RESP) begin
			res_valid = 1'b1;
		end else if (state_q == ST_EMIT) begin
			res_valid = 1'b1;
			res.page_out = emit_ext[pfla_pkg::PAGE_OUT_W-1:0];
			res.status = pfla_pkg::STATUS_OK;
			res.last = batch_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= PW'(NUM_PAGES);
			used_q <= '0;
			first_q <= 1'b0;
			n_q <= '0;
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						case (req.op)
							pfla_pkg::OP_FORMAT: begin
								idx_q <= '0;
								state_q <= ST_FORMAT;
							end
							pfla_pkg::OP_ALLOC: begin
								if (alloc_zero || alloc_over) begin
									state_q <= ST_RESP;
								end else begin
									n_q <= '0;
									first_q <= 1'b1;
									state_q <= ST_ALLOC;
								end
							end
							pfla_pkg::OP_FREE: begin
								if (!free_bad) begin
									head_q <= page_ext[PW-1:0];
									if (used_q != '0) begin
										used_q <= used_q - pfla_pkg::USED_W'(1);
									end
								end
								state_q <= ST_RESP;
							end
							default: ;
						endcase
					end
				end
				ST_FORMAT: begin
					idx_q <= idx_nxt[PW-1:0];
					if (fmt_last) begin
						head_q <= reserved;
						used_q <= pfla_pkg::USED_W'(reserved);
						state_q <= ST_RESP;
					end
				end
				ST_ALLOC: begin
					// Nothing is committed until the whole batch is found on the list.
					if (cur_null) begin
						state_q <= ST_RESP;
					end else begin
						first_q <= 1'b0;
						if (batch_last) begin
							state_q <= ST_ALLOC_FIN;
						end else begin
							n_q <= n_nxt[NW-1:0];
						end
					end
				end
				ST_ALLOC_FIN: begin
					head_q <= rd_q;
					used_q <= used_q + pfla_pkg::USED_W'(count_q);
					n_q <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res_ready) begin
						if (batch_last) begin
							state_q <= ST_IDLE;
						end else begin
							n_q <= n_nxt[NW-1:0];
						end
					end
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				count_q <= req.count;
				resp_status_q <= idle_status;
			end
			ST_FORMAT: resp_status_q <= pfla_pkg::STATUS_OK;
			ST_ALLOC: begin
				if (cur_null) begin
					resp_status_q <= pfla_pkg::STATUS_SHORT;
				end else begin
					batch_q[n_q[BW-1:0]] <= cur_w;
				end
			end
			default: ;
		endcase
	end

endmodule
